FILE: hw/rtl/skce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// skce_pkg: split-kmer compare engine shared types and constants
// Table geometry, op and outcome codes, payload words, control/status bundles.
// -----------------------------------------------------------------------------
package skce_pkg;

  // Table depth must be a power of two: the start slot is the low hash bits.
  localparam int TABLE_ENTRIES = 65536;
  localparam int NUM_SAMPLES   = 64;
  localparam int KEY_BYTES     = 16;

  localparam int ADDR_W   = $clog2(TABLE_ENTRIES);
  localparam int TSIZE_W  = ADDR_W + 1;
  localparam int SROW_AW  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int CNT_W    = ((ADDR_W > 7) ? ADDR_W : 7) + 1;
  localparam int NCLASS   = 6;
  localparam int CNT_BITS = 32;
  localparam int ROW_W    = NCLASS * CNT_BITS;
  localparam int TBL_W    = 1 + 64 + 64 + 8;
  localparam int HASH_LAST = 9;

  localparam logic [127:0] KEY_MASK = (KEY_BYTES >= 16) ? '1 :
      ((128'(1) << (KEY_BYTES * 8)) - 128'(1));

  localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_C2 = 64'hFF51AFD7ED558CCD;
  localparam logic [7:0]  BASE_N  = 8'h4E;
  localparam logic [7:0]  LOWER_A = 8'h61;
  localparam logic [7:0]  LOWER_Z = 8'h7A;
  localparam logic [7:0]  CASE_OFS = 8'h20;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_CLASSIFY = 3'd1;
  localparam logic [2:0] OP_END_LINE = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [3:0] OUT_INSERTED = 4'd0;
  localparam logic [3:0] OUT_MARKED_N = 4'd1;
  localparam logic [3:0] OUT_FULL     = 4'd2;
  localparam logic [3:0] OUT_CLASS0   = 4'd3;

  localparam logic [2:0] CLS_N_BOTH    = 3'd0;
  localparam logic [2:0] CLS_N_QUERY   = 3'd1;
  localparam logic [2:0] CLS_N_SUBJECT = 3'd2;
  localparam logic [2:0] CLS_MATCH     = 3'd3;
  localparam logic [2:0] CLS_SNP       = 3'd4;
  localparam logic [2:0] CLS_ONLY_SUBJ = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [7:0]  middle_base;
    logic [63:0] sample_mask;
    logic [5:0]  sample_index;
  } skce_in_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [31:0] count_n_both;
    logic [31:0] count_n_query;
    logic [31:0] count_n_subject;
    logic [31:0] count_match;
    logic [31:0] count_snp;
    logic [31:0] count_only_subject;
    logic [31:0] count_only_query;
  } skce_out_t;

  typedef struct packed {
    logic             load;
    logic             hash_en;
    logic [3:0]       hstep;
    logic             tbl_rd;
    logic             tbl_clr;
    logic             idx_adv;
    logic             ins;
    logic             mark_n;
    logic             cls;
    logic             cls_found;
    logic             res_full;
    logic             srow_rd;
    logic             srow_use_sidx;
    logic             srow_wr;
    logic             line_clr;
    logic             cnt_clr;
    logic             rd_cap;
    logic             rd_fin;
    logic             emit;
    logic [CNT_W-1:0] cnt;
  } skce_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ent_valid;
    logic       key_eq;
    logic       mask_bit;
    logic       sidx_ok;
  } skce_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/skce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// skce_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module skce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/skce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// skce_ctrl: sequencer of the split-kmer compare engine
// Steps the table clear, hash, probe, end-line and read sequences.
// -----------------------------------------------------------------------------
module skce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire skce_pkg::skce_sts_t sts,
  output skce_pkg::skce_cmd_t      cmd
);
  import skce_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_HASH = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_PCMP = 4'd5;
  localparam logic [3:0] S_EL   = 4'd6;
  localparam logic [3:0] S_ELW  = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_RDC  = 4'd9;
  localparam logic [3:0] S_RDF  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.hstep  = cnt[3:0];
    in_ready   = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_CLR: begin
        cmd.tbl_clr = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          OP_INSERT, OP_CLASSIFY: state_next = S_HASH;
          OP_END_LINE:            state_next = S_EL;
          OP_READ:                state_next = S_RD;
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_EMIT;
          end
          default:                state_next = S_EMIT;
        endcase
      end
      S_HASH: begin
        cmd.hash_en = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == CNT_W'(HASH_LAST)) begin
          cnt_next   = '0;
          state_next = S_PRD;
        end
      end
      S_PRD: begin
        cmd.tbl_rd = 1'b1;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        state_next = S_EMIT;
        if (!sts.ent_valid) begin
          if (sts.op == OP_INSERT) begin
            cmd.ins = 1'b1;
          end else begin
            cmd.cls = 1'b1;
          end
        end else if (sts.key_eq) begin
          if (sts.op == OP_INSERT) begin
            cmd.mark_n = 1'b1;
          end else begin
            cmd.cls       = 1'b1;
            cmd.cls_found = 1'b1;
          end
        end else if (cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
          // every slot probed: table full, key absent
          if (sts.op == OP_INSERT) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.cls = 1'b1;
          end
        end else begin
          cmd.idx_adv = 1'b1;
          cnt_next    = cnt + 1'b1;
          state_next  = S_PRD;
        end
      end
      S_EL: begin
        if (cnt == CNT_W'(NUM_SAMPLES)) begin
          cmd.line_clr = 1'b1;
          state_next   = S_EMIT;
        end else if (sts.mask_bit) begin
          cmd.srow_rd = 1'b1;
          state_next  = S_ELW;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ELW: begin
        cmd.srow_wr = 1'b1;
        cnt_next    = cnt + 1'b1;
        state_next  = S_EL;
      end
      S_RD: begin
        if (sts.sidx_ok) begin
          cmd.srow_rd       = 1'b1;
          cmd.srow_use_sidx = 1'b1;
          state_next        = S_RDC;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RDC: begin
        cmd.rd_cap = 1'b1;
        state_next = S_RDF;
      end
      S_RDF: begin
        cmd.rd_fin = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/skce_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// skce_dp: datapath of the split-kmer compare engine
// Hash unit, key table, line counters, per-sample count rows, result words.
// -----------------------------------------------------------------------------
module skce_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire skce_pkg::skce_in_t  in_data,
  input  wire skce_pkg::skce_cmd_t cmd,
  output skce_pkg::skce_sts_t      sts,
  output skce_pkg::skce_out_t      out_data
);
  import skce_pkg::*;

  // latched request
  logic [2:0]  op;
  logic [63:0] klo, khi;
  logic [7:0]  base;
  logic [63:0] smask;
  logic [5:0]  sidx;

  // hash unit
  logic [63:0] prod, acc, h1;
  logic [31:0] mul_a, mul_b;
  logic        phase;
  logic [2:0]  sub;
  logic [63:0] hx, hc, ht, hy;
  logic [ADDR_W-1:0] idx;

  // table
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;
  logic [TSIZE_W-1:0] table_size;

  // counts
  logic [CNT_BITS-1:0] line_cnt [NCLASS];
  logic [NUM_SAMPLES-1:0] row_valid;
  logic                row_valid_q;
  logic [SROW_AW-1:0]  srow_raddr, srow_waddr;
  logic [ROW_W-1:0]    srow_rdata, row_eff, row_new;
  logic [34:0]         shared;
  logic [34:0]         oq_diff;

  // classification
  logic [7:0] q_base, s_base;
  logic [2:0] cls_code;

  skce_out_t res;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_data.op;
      klo   <= in_data.key_low & KEY_MASK[63:0];
      khi   <= in_data.key_high & KEY_MASK[127:64];
      base  <= in_data.middle_base;
      smask <= in_data.sample_mask;
      sidx  <= in_data.sample_index;
    end
  end

  // Hash: two rounds of a 64x64 low-half product from three 32x32 products,
  // each followed by an xor-shift fold.
  always_comb begin
    phase = (cmd.hstep >= 4'd5);
    sub   = phase ? 3'(cmd.hstep - 4'd5) : cmd.hstep[2:0];
    hx    = phase ? h1 : khi;
    hc    = phase ? HASH_C2 : HASH_C1;
    case (sub)
      3'd0:    begin mul_a = hx[31:0];  mul_b = hc[31:0];  end
      3'd1:    begin mul_a = hx[63:32]; mul_b = hc[31:0];  end
      default: begin mul_a = hx[31:0];  mul_b = hc[63:32]; end
    endcase
    ht = phase ? acc : (klo ^ acc);
    hy = ht ^ (ht >> 33);
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
      case (sub)
        3'd1:          acc <= prod;
        3'd2, 3'd3:    acc <= acc + {prod[31:0], 32'd0};
        3'd4: begin
          if (phase) begin
            idx <= hy[ADDR_W-1:0];
          end else begin
            h1 <= hy;
          end
        end
        default: ;
      endcase
    end else if (cmd.idx_adv) begin
      idx <= idx + 1'b1;
    end
  end

  // table access
  always_comb begin
    tbl_we    = cmd.tbl_clr || cmd.ins || cmd.mark_n;
    tbl_waddr = cmd.tbl_clr ? cmd.cnt[ADDR_W-1:0] : idx;
    tbl_wdata = cmd.tbl_clr ? '0 : {1'b1, klo, khi, cmd.mark_n ? BASE_N : base};
  end

  skce_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_ENTRIES)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (cmd.tbl_rd),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cmd.ins) begin
      table_size <= table_size + 1'b1;
    end
  end

  // classification of a subject word against the probed entry
  always_comb begin
    q_base = tbl_rdata[7:0];
    s_base = (base >= LOWER_A && base <= LOWER_Z) ? (base - CASE_OFS) : base;
    if (!cmd.cls_found) begin
      cls_code = CLS_ONLY_SUBJ;
    end else if (q_base == BASE_N && s_base == BASE_N) begin
      cls_code = CLS_N_BOTH;
    end else if (q_base == BASE_N) begin
      cls_code = CLS_N_QUERY;
    end else if (s_base == BASE_N) begin
      cls_code = CLS_N_SUBJECT;
    end else if (q_base == s_base) begin
      cls_code = CLS_MATCH;
    end else begin
      cls_code = CLS_SNP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.line_clr || cmd.cnt_clr) begin
      for (int c = 0; c < NCLASS; c++) begin
        line_cnt[c] <= '0;
      end
    end else if (cmd.cls) begin
      for (int c = 0; c < NCLASS; c++) begin
        if (cls_code == 3'(c)) begin
          line_cnt[c] <= sat_add(line_cnt[c], CNT_BITS'(1));
        end
      end
    end
  end

  // per-sample count rows; an invalid row reads as zero
  always_comb begin
    srow_raddr = cmd.srow_use_sidx ? SROW_AW'(sidx) : cmd.cnt[SROW_AW-1:0];
    srow_waddr = cmd.cnt[SROW_AW-1:0];
    row_eff    = row_valid_q ? srow_rdata : '0;
    for (int c = 0; c < NCLASS; c++) begin
      row_new[c*CNT_BITS +: CNT_BITS] = sat_add(row_eff[c*CNT_BITS +: CNT_BITS], line_cnt[c]);
    end
  end

  skce_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SAMPLES)) u_srow (
    .clk   (clk),
    .we    (cmd.srow_wr),
    .waddr (srow_waddr),
    .wdata (row_new),
    .re    (cmd.srow_rd),
    .raddr (srow_raddr),
    .rdata (srow_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      row_valid <= '0;
    end else if (cmd.srow_wr) begin
      row_valid[srow_waddr] <= 1'b1;
    end
    if (cmd.srow_rd) begin
      row_valid_q <= row_valid[srow_raddr];
    end
  end

  always_comb begin
    oq_diff = 35'(table_size) - shared;
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= '0;
    end else begin
      if (cmd.mark_n) begin
        res.outcome <= OUT_MARKED_N;
      end
      if (cmd.ins) begin
        res.outcome <= OUT_INSERTED;
      end
      if (cmd.res_full) begin
        res.outcome <= OUT_FULL;
      end
      if (cmd.cls) begin
        res.outcome <= OUT_CLASS0 + 4'(cls_code);
      end
      if (cmd.rd_cap) begin
        res.count_n_both       <= row_eff[0*CNT_BITS +: CNT_BITS];
        res.count_n_query      <= row_eff[1*CNT_BITS +: CNT_BITS];
        res.count_n_subject    <= row_eff[2*CNT_BITS +: CNT_BITS];
        res.count_match        <= row_eff[3*CNT_BITS +: CNT_BITS];
        res.count_snp          <= row_eff[4*CNT_BITS +: CNT_BITS];
        res.count_only_subject <= row_eff[5*CNT_BITS +: CNT_BITS];
        shared <= 35'(row_eff[0*CNT_BITS +: CNT_BITS]) + 35'(row_eff[1*CNT_BITS +: CNT_BITS])
                + 35'(row_eff[2*CNT_BITS +: CNT_BITS]) + 35'(row_eff[3*CNT_BITS +: CNT_BITS])
                + 35'(row_eff[4*CNT_BITS +: CNT_BITS]);
      end
      if (cmd.rd_fin) begin
        res.count_only_query <= (shared >= 35'(table_size)) ? '0 : oq_diff[31:0];
      end
    end
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  always_comb begin
    sts.op        = op;
    sts.ent_valid = tbl_rdata[TBL_W-1];
    sts.key_eq    = (tbl_rdata[TBL_W-2 -: 64] == klo) && (tbl_rdata[71:8] == khi);
    sts.mask_bit  = smask[cmd.cnt[5:0]];
    sts.sidx_ok   = ({1'b0, sidx} < 7'(NUM_SAMPLES));
  end

endmodule
`default_nettype wire

FILE: hw/rtl/split_kmer_compare_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// split_kmer_compare_engine: query kmer table and per-sample comparison counts
// Inserts query keys, classifies subject keys, accumulates per-sample counts.
// -----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request word; output channel
// out_valid/out_ready returns exactly one result word per request.
// Steps per request:
//   insert / classify: hashing and setup, then a read and a compare per
//   table probe (linear probing of the key table RAM, registered read),
//   then the result is emitted.
//   end line: a test of each sample bit, with a read and a write of the
//   count row for each selected sample (read-modify-write), then emit.
//   read: row read, capture, finish, emit; clear counts and unused ops emit directly.
// One request is worked at a time. A finished result sits in the output
// register while the next request is taken; a stalled receiver holds the
// engine only when a second result is ready to go out.
// After reset the key table is swept clear, one entry per cycle, with
// in_ready low; counters reset at once.
// -----------------------------------------------------------------------------
module split_kmer_compare_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skce_pkg::skce_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skce_pkg::skce_out_t      out_data
);
  import skce_pkg::*;

  skce_cmd_t cmd;
  skce_sts_t sts;

  skce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skce_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: bench/tb_split_kmer_compare_engine.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_split_kmer_compare_engine: self-checking bench for the kmer compare engine
// Drives query inserts, subject classifications, end-of-line folds, sample
// reads and clears with random gaps and output stalls. A local copy of the
// table and counters predicts each result word, compared field by field.
// -----------------------------------------------------------------------------
module tb_split_kmer_compare_engine;
  import skce_pkg::*;

  localparam int GAP_MAX  = 19;
  localparam int WDOG_MAX = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  skce_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  skce_out_t out_data;

  split_kmer_compare_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Local copy of the query table and counters
  logic [63:0] tbl_lo[int];
  logic [63:0] tbl_hi[int];
  logic [7:0]  tbl_base[int];
  int unsigned tbl_size;
  logic [31:0] line_cnt[NCLASS];
  logic [31:0] samp_cnt[NUM_SAMPLES][NCLASS];

  skce_out_t   pending_q[$];
  logic [127:0] key_pool[$];
  int  errors;
  int  words_sent;
  int  words_checked;
  int  gap_max;
  int  stall_max;
  int  stall_left;
  int  wdog;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int hash_slot(logic [63:0] lo, logic [63:0] hi);
    logic [63:0] h;
    h = lo ^ (hi * HASH_C1);
    h ^= h >> 33;
    h *= HASH_C2;
    h ^= h >> 33;
    return int'(h % TABLE_ENTRIES);
  endfunction

  // Returns 1 when found; slot holds the hit or the first free entry.
  function automatic bit probe_table(logic [63:0] lo, logic [63:0] hi, output int slot);
    int idx;
    idx = hash_slot(lo, hi);
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (!tbl_lo.exists(idx)) begin
        slot = idx;
        return 1'b0;
      end
      if (tbl_lo[idx] == lo && tbl_hi[idx] == hi) begin
        slot = idx;
        return 1'b1;
      end
      idx = (idx + 1) % TABLE_ENTRIES;
    end
    slot = 0;
    return 1'b0;
  endfunction

  function automatic skce_out_t compare_kmer(skce_in_t w);
    skce_out_t   r;
    logic [127:0] key;
    logic [7:0]  b;
    logic [7:0]  q;
    int          slot;
    int          c;
    logic [63:0] shared;
    r   = '0;
    key = {w.key_high, w.key_low} & KEY_MASK;
    b   = w.middle_base;
    case (w.op)
      OP_INSERT: begin
        if (probe_table(key[63:0], key[127:64], slot)) begin
          tbl_base[slot] = BASE_N;
          r.outcome = OUT_MARKED_N;
        end else if (tbl_size >= TABLE_ENTRIES) begin
          r.outcome = OUT_FULL;
        end else begin
          tbl_lo[slot]   = key[63:0];
          tbl_hi[slot]   = key[127:64];
          tbl_base[slot] = b;
          tbl_size++;
          r.outcome = OUT_INSERTED;
        end
      end
      OP_CLASSIFY: begin
        if (b >= LOWER_A && b <= LOWER_Z) b = b - CASE_OFS;
        if (probe_table(key[63:0], key[127:64], slot)) begin
          q = tbl_base[slot];
          if (q == BASE_N && b == BASE_N) c = CLS_N_BOTH;
          else if (q == BASE_N) c = CLS_N_QUERY;
          else if (b == BASE_N) c = CLS_N_SUBJECT;
          else if (q == b) c = CLS_MATCH;
          else c = CLS_SNP;
        end else begin
          c = CLS_ONLY_SUBJ;
        end
        line_cnt[c] = sat_inc(line_cnt[c], 32'd1);
        r.outcome = OUT_CLASS0 + 4'(c);
      end
      OP_END_LINE: begin
        for (int i = 0; i < NUM_SAMPLES; i++)
          if (w.sample_mask[i])
            for (int k = 0; k < NCLASS; k++)
              samp_cnt[i][k] = sat_inc(samp_cnt[i][k], line_cnt[k]);
        for (int k = 0; k < NCLASS; k++) line_cnt[k] = '0;
      end
      OP_READ: begin
        if (w.sample_index < NUM_SAMPLES) begin
          r.count_n_both       = samp_cnt[w.sample_index][CLS_N_BOTH];
          r.count_n_query      = samp_cnt[w.sample_index][CLS_N_QUERY];
          r.count_n_subject    = samp_cnt[w.sample_index][CLS_N_SUBJECT];
          r.count_match        = samp_cnt[w.sample_index][CLS_MATCH];
          r.count_snp          = samp_cnt[w.sample_index][CLS_SNP];
          r.count_only_subject = samp_cnt[w.sample_index][CLS_ONLY_SUBJ];
          shared = 64'(r.count_n_both) + r.count_n_query + r.count_n_subject
                 + r.count_match + r.count_snp;
          r.count_only_query = (shared >= tbl_size) ? '0 : 32'(tbl_size - shared);
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < NCLASS; k++) line_cnt[k] = '0;
        for (int i = 0; i < NUM_SAMPLES; i++)
          for (int k = 0; k < NCLASS; k++) samp_cnt[i][k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_base();
    logic [7:0] set[10];
    set = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E, 8'h61, 8'h63, 8'h67, 8'h74, 8'h6E};
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return set[$urandom_range(0, 9)];
  endfunction

  task automatic send_word(skce_in_t w);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(compare_kmer(w));
    words_sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [127:0] key, logic [7:0] b,
                         logic [63:0] mask, logic [5:0] sidx);
    skce_in_t w;
    w.op           = op;
    w.key_low      = key[63:0];
    w.key_high     = key[127:64];
    w.middle_base  = b;
    w.sample_mask  = mask;
    w.sample_index = sidx;
    send_word(w);
  endtask

  // Hold off the sender until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_insert_edges();
    send_op(OP_INSERT, '0, 8'h41, rand64(), 6'($urandom));
    send_op(OP_INSERT, '1, 8'h43, rand64(), 6'($urandom));
    send_op(OP_INSERT, {64'h0, 64'h1}, 8'h00, '0, '0);
    send_op(OP_INSERT, {64'h1, 64'h0}, 8'hFF, '1, '1);
    send_op(OP_INSERT, {64'h5, 64'h7}, 8'h4E, '0, '0);
    // repeat inserts mark the base N
    send_op(OP_INSERT, '1, 8'h47, '0, '0);
    send_op(OP_INSERT, {64'h1, 64'h0}, 8'h54, '0, '0);
  endtask

  task automatic test_classify_cases();
    send_op(OP_CLASSIFY, '1, 8'h6E, '0, '0);              // N both, lower-case
    send_op(OP_CLASSIFY, '1, 8'h41, '0, '0);              // N in query
    send_op(OP_CLASSIFY, '0, 8'h4E, '0, '0);              // N in subject
    send_op(OP_CLASSIFY, '0, 8'h61, '0, '0);              // match after upper-case
    send_op(OP_CLASSIFY, {64'h0, 64'h1}, 8'h00, '0, '0);  // match on zero byte
    send_op(OP_CLASSIFY, {64'h0, 64'h1}, 8'h60, '0, '0);  // snp, below 'a'
    send_op(OP_CLASSIFY, {64'h5, 64'h7}, 8'h7B, '0, '0);  // N query, above 'z'
    send_op(OP_CLASSIFY, '0, 8'h7A, '0, '0);              // snp, 'z' upper-cased
    send_op(OP_CLASSIFY, {64'h9, 64'h9}, 8'hFF, '0, '0);  // only subject
  endtask

  task automatic test_line_and_read();
    send_op(OP_END_LINE, '0, '0, '1, '0);
    send_op(OP_READ, '0, '0, '0, 6'd0);
    send_op(OP_READ, '0, '0, '0, 6'd63);
    send_op(OP_END_LINE, '0, '0, '0, '0);
    send_op(OP_READ, '1, '1, '1, 6'd17);
  endtask

  task automatic test_unused_and_clear();
    send_op(3'd5, '1, '1, '1, '1);
    send_op(3'd6, rand64(), 8'h41, '1, 6'd3);
    send_op(3'd7, '1, 8'h4E, '1, 6'd5);
    send_op(OP_CLEAR, '1, '1, '1, '1);
    send_op(OP_READ, '0, '0, '0, 6'd0);
  endtask

  task automatic random_key(output logic [127:0] key);
    if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else
      key = {rand64(), rand64()};
  endtask

  task automatic test_random_lines(int n_items);
    logic [127:0] key;
    int           sent;
    int           len;
    sent = 0;
    while (sent < n_items) begin
      // alternate busy stretches with back-to-back traffic
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      len = $urandom_range(1, 4);
      repeat (len) begin
        random_key(key);
        if ($urandom_range(0, 3) != 0 || key_pool.size() == 0) begin
          key = {rand64(), rand64()};
          key_pool.push_back(key);
        end
        send_op(OP_INSERT, key, pick_base(), rand64(), 6'($urandom));
        sent++;
      end
      len = $urandom_range(3, 20);
      repeat (len) begin
        random_key(key);
        send_op(OP_CLASSIFY, key, pick_base(), rand64(), 6'($urandom));
        sent++;
      end
      send_op(OP_END_LINE, rand64(), 8'($urandom), rand64(), 6'($urandom));
      sent++;
      if ($urandom_range(0, 2) == 0) begin
        send_op(OP_READ, rand64(), 8'($urandom), rand64(), 6'($urandom));
        sent++;
      end
      case ($urandom_range(0, 29))
        0: send_op(OP_CLEAR, rand64(), 8'($urandom), rand64(), 6'($urandom));
        1: send_op(3'($urandom_range(5, 7)), rand64(), 8'($urandom), rand64(),
                   6'($urandom));
        2: drain();
        default: ;
      endcase
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("MISMATCH word %0d %s: expected %0d got %0d",
                 words_checked, name, exp_v, act_v);
    end
  endtask

  // Output stall draw and result compare
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    skce_out_t e;
    if (!rst && out_valid && out_ready) begin
      stall_left <= $urandom_range(0, stall_max);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("MISMATCH: unexpected result word");
      end else begin
        e = pending_q.pop_front();
        check_field("outcome", 32'(e.outcome), 32'(out_data.outcome));
        check_field("n_both", e.count_n_both, out_data.count_n_both);
        check_field("n_query", e.count_n_query, out_data.count_n_query);
        check_field("n_subject", e.count_n_subject, out_data.count_n_subject);
        check_field("match", e.count_match, out_data.count_match);
        check_field("snp", e.count_snp, out_data.count_snp);
        check_field("only_subject", e.count_only_subject, out_data.count_only_subject);
        check_field("only_query", e.count_only_query, out_data.count_only_query);
      end
      words_checked++;
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    gap_max       = GAP_MAX;
    stall_max     = GAP_MAX;
    stall_left    = 0;
    wdog          = 0;
    tbl_size      = 0;
    for (int k = 0; k < NCLASS; k++) line_cnt[k] = '0;
    for (int i = 0; i < NUM_SAMPLES; i++)
      for (int k = 0; k < NCLASS; k++) samp_cnt[i][k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_insert_edges();
    test_classify_cases();
    test_line_and_read();
    drain();
    test_unused_and_clear();
    test_random_lines(1900);
    drain();
    repeat (200) @(posedge clk);

    $display("Covered %0d words in, %0d results checked, %0d query keys in table.",
             words_sent, words_checked, tbl_size);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatch count: %0d", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
